/* rtl/qvr_pkg.sv */
// shared widths, types and constants for the quaternion vector rotator
package qvr_pkg;

    localparam int QUAT_BITS = 16;
    localparam int VEC_BITS  = 24;

    // product and sum widths
    localparam int SQ_W   = 2 * QUAT_BITS;
    localparam int QV_W   = QUAT_BITS + VEC_BITS;
    localparam int LEN_W  = SQ_W + 1;
    localparam int S_W    = SQ_W + 2;
    localparam int DOT_W  = QV_W + 2;
    localparam int CRS_W  = QV_W + 1;
    localparam int SV_W   = S_W + VEC_BITS;
    localparam int DU_W   = DOT_W + QUAT_BITS;
    localparam int WC_W   = QUAT_BITS + CRS_W;
    localparam int NUM_W  = SV_W + 2;

    // divider widths
    localparam int QUO_W     = VEC_BITS + 2;
    localparam int DIV_STEPS = QUO_W;
    localparam int DEN_W     = LEN_W + 1;
    localparam int REM_W     = NUM_W + 2;
    localparam int RES_W     = QUO_W + 1;

    localparam logic signed [RES_W-1:0] RES_MAX = RES_W'((64'sd1 <<< (VEC_BITS - 1)) - 1);
    localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(-(64'sd1 <<< (VEC_BITS - 1)));

    typedef logic signed [QUAT_BITS-1:0] t_quat;
    typedef logic signed [VEC_BITS-1:0]  t_vec;

    // per-item control carried alongside the divider lanes
    typedef struct packed {
        logic       vld;
        logic       deg;
        logic [2:0] neg;
    } t_side;

endpackage

/* rtl/qvr_if.sv */
// request and response channel interfaces
interface qvr_req_if
    import qvr_pkg::*;
();
    logic  valid;
    logic  ready;
    t_quat quat_x;
    t_quat quat_y;
    t_quat quat_z;
    t_quat quat_w;
    t_vec  vec_x;
    t_vec  vec_y;
    t_vec  vec_z;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
                    input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
                    output ready);
endinterface

interface qvr_rsp_if
    import qvr_pkg::*;
();
    logic valid;
    logic ready;
    t_vec rot_x;
    t_vec rot_y;
    t_vec rot_z;
    logic degenerate;
    logic saturated;

    modport source (output valid, rot_x, rot_y, rot_z, degenerate, saturated, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, degenerate, saturated, output ready);
endinterface

/* rtl/qvr_div.sv */
// pipelined restoring divider, one quotient bit per stage
module qvr_div
    import qvr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [REM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    logic [REM_W-1:0] r_rem [0:DIV_STEPS];
    logic [DEN_W-1:0] r_den [0:DIV_STEPS];
    logic [QUO_W-1:0] r_quo [0:DIV_STEPS];

    // load stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    // one trial subtract per stage, highest quotient bit first
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        localparam int SH = DIV_STEPS - 1 - k;
        logic [REM_W:0]   n_diff;
        logic [REM_W-1:0] n_rem;
        logic [QUO_W-1:0] n_quo;

        always_comb begin
            n_diff = {1'b0, r_rem[k]} - ((REM_W+1)'(r_den[k]) << SH);
            n_rem  = r_rem[k];
            n_quo  = r_quo[k];
            if (!n_diff[REM_W]) begin
                n_rem     = n_diff[REM_W-1:0];
                n_quo[SH] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_rem;
                r_den[k+1] <= r_den[k];
                r_quo[k+1] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS];

endmodule

/* rtl/quaternion_vector_rotate_top.sv */
// top level of the quaternion vector rotator, q * v * q^-1
//
// i_req carries one quaternion (signed Q1.14) and one vector (signed Q15.8)
// per request; o_rsp returns the rotated vector (signed Q15.8, saturated)
// with a degenerate flag (zero-length quaternion) and a saturated flag.
// Both channels move a request when valid and ready are high at a clock edge.
// From request to response the data pass four arithmetic stages
// (squares and products, sums, second products, numerators), a load stage
// and 26 quotient-bit stages of the per-component restoring divider,
// and the rounding and clipping output register.
// Throughput is one request per cycle while the output is not stalled; the
// three components use their own divider lanes, so no lane is shared between them.
// The whole pipeline advances together. When the receiver holds ready low
// with a response waiting, every stage holds and i_req.ready drops; nothing
// is lost or repeated. Empty slots keep moving while the output is free.
// Synchronous reset clears all valid bits; data registers are not reset.
module quaternion_vector_rotate_top
    import qvr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    qvr_req_if.sink   i_req,
    qvr_rsp_if.source o_rsp
);

    logic en;

    // stage valids
    logic [3:0] r_vld;
    t_side      r_side [0:DIV_STEPS];

    // stage 1: squares and first products
    logic signed [SQ_W-1:0] r1_sq  [0:3];
    logic signed [QV_W-1:0] r1_dot [0:2];
    logic signed [QV_W-1:0] r1_cp  [0:2];
    logic signed [QV_W-1:0] r1_cm  [0:2];
    t_quat r1_u [0:2];
    t_quat r1_w;
    t_vec  r1_v [0:2];

    // stage 2: sums
    logic [LEN_W-1:0]        r2_len;
    logic signed [S_W-1:0]   r2_s;
    logic signed [DOT_W-1:0] r2_d;
    logic signed [CRS_W-1:0] r2_crs [0:2];
    t_quat r2_u [0:2];
    t_quat r2_w;
    t_vec  r2_v [0:2];

    // stage 3: second products
    logic [LEN_W-1:0]       r3_len;
    logic signed [SV_W-1:0] r3_sv [0:2];
    logic signed [DU_W-1:0] r3_du [0:2];
    logic signed [WC_W-1:0] r3_wc [0:2];

    // stage 4: numerators
    logic [LEN_W-1:0]        r4_len;
    logic signed [NUM_W-1:0] r4_n [0:2];

    // divider inputs and outputs
    logic [NUM_W-1:0] n_mag [0:2];
    logic [REM_W-1:0] n_num [0:2];
    logic [DEN_W-1:0] n_den;
    logic [QUO_W-1:0] quo   [0:2];
    t_side            n_side;

    // output stage
    logic r_out_vld;
    t_vec r_rot [0:2];
    logic r_deg;
    logic r_sat;
    t_vec n_rot [0:2];
    logic n_sat;

    t_quat in_u [0:2];
    t_vec  in_v [0:2];

    assign en          = !r_out_vld || o_rsp.ready;
    assign i_req.ready = en;

    assign in_u[0] = i_req.quat_x;
    assign in_u[1] = i_req.quat_y;
    assign in_u[2] = i_req.quat_z;
    assign in_v[0] = i_req.vec_x;
    assign in_v[1] = i_req.vec_y;
    assign in_v[2] = i_req.vec_z;

    // valid chain through the arithmetic stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[2:0], i_req.valid};
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_sq[i]  <= SQ_W'(in_u[i] * in_u[i]);
                r1_dot[i] <= QV_W'(in_u[i] * in_v[i]);
                r1_cp[i]  <= QV_W'(in_u[(i+1)%3] * in_v[(i+2)%3]);
                r1_cm[i]  <= QV_W'(in_u[(i+2)%3] * in_v[(i+1)%3]);
                r1_u[i]   <= in_u[i];
                r1_v[i]   <= in_v[i];
            end
            r1_sq[3] <= SQ_W'(i_req.quat_w * i_req.quat_w);
            r1_w     <= i_req.quat_w;
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_len <= LEN_W'(r1_sq[0]) + LEN_W'(r1_sq[1]) + LEN_W'(r1_sq[2])
                      + LEN_W'(r1_sq[3]);
            r2_s   <= S_W'(r1_sq[3]) - S_W'(r1_sq[0]) - S_W'(r1_sq[1]) - S_W'(r1_sq[2]);
            r2_d   <= DOT_W'(r1_dot[0]) + DOT_W'(r1_dot[1]) + DOT_W'(r1_dot[2]);
            for (int i = 0; i < 3; i++) begin
                r2_crs[i] <= CRS_W'(r1_cp[i]) - CRS_W'(r1_cm[i]);
                r2_u[i]   <= r1_u[i];
                r2_v[i]   <= r1_v[i];
            end
            r2_w <= r1_w;
        end
    end

    // stage 3
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_len <= r2_len;
            for (int i = 0; i < 3; i++) begin
                r3_sv[i] <= SV_W'(r2_s * r2_v[i]);
                r3_du[i] <= DU_W'(r2_d * r2_u[i]);
                r3_wc[i] <= WC_W'(r2_w * r2_crs[i]);
            end
        end
    end

    // stage 4
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_len <= r3_len;
            for (int i = 0; i < 3; i++) begin
                r4_n[i] <= NUM_W'(r3_sv[i]) + (NUM_W'(r3_du[i]) <<< 1)
                           + (NUM_W'(r3_wc[i]) <<< 1);
            end
        end
    end

    // magnitude plus half divisor for round-half-away division
    always_comb begin
        n_den      = {r4_len, 1'b0};
        n_side.vld = r_vld[3];
        n_side.deg = (r4_len == '0);
        for (int i = 0; i < 3; i++) begin
            n_side.neg[i] = r4_n[i][NUM_W-1];
            n_mag[i]      = r4_n[i][NUM_W-1] ? NUM_W'(-r4_n[i]) : NUM_W'(r4_n[i]);
            n_num[i]      = (REM_W'(n_mag[i]) << 1) + REM_W'(r4_len);
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        qvr_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (n_num[i]),
            .i_den (n_den),
            .o_quo (quo[i])
        );
    end

    // side info follows the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_side[k].vld <= 1'b0;
            end
        end else if (en) begin
            r_side[0] <= n_side;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_side[k+1] <= r_side[k];
            end
        end
    end

    // sign restore and clipping
    always_comb begin
        logic signed [RES_W-1:0] res;
        n_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            res = r_side[DIV_STEPS].neg[i] ? -RES_W'(quo[i]) : RES_W'(quo[i]);
            if (res > RES_MAX) begin
                n_rot[i] = VEC_BITS'(RES_MAX);
                n_sat    = 1'b1;
            end else if (res < RES_MIN) begin
                n_rot[i] = VEC_BITS'(RES_MIN);
                n_sat    = 1'b1;
            end else begin
                n_rot[i] = VEC_BITS'(res);
            end
        end
        if (r_side[DIV_STEPS].deg) begin
            for (int i = 0; i < 3; i++) begin
                n_rot[i] = '0;
            end
            n_sat = 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_side[DIV_STEPS].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot <= n_rot;
            r_deg <= r_side[DIV_STEPS].deg;
            r_sat <= n_sat;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.rot_x      = r_rot[0];
    assign o_rsp.rot_y      = r_rot[1];
    assign o_rsp.rot_z      = r_rot[2];
    assign o_rsp.degenerate = r_deg;
    assign o_rsp.saturated  = r_sat;

endmodule
